/* hdl/hmsclk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmsclk_pkg: shared types, codes and time helpers
// Request and result structs, register indexes, reset values and the
// minute carry and 12/24 conversion used by the clock core.
// ----------------------------------------------------------------------------
package hmsclk_pkg;

   // request kinds
   localparam logic OP_TIMEBASE = 1'b0;
   localparam logic OP_SCAN     = 1'b1;

   // configuration register indexes
   localparam logic CSR_TICKS_PER_SECOND = 1'b0;
   localparam logic CSR_DEBOUNCE_SCANS   = 1'b1;

   localparam logic [7:0] TICKS_PER_SECOND_RESET = 8'd8;
   localparam logic [7:0] DEBOUNCE_SCANS_RESET   = 8'd10;

   localparam logic [4:0] HOUR_RESET   = 5'd15;
   localparam logic [5:0] MINUTE_RESET = 6'd58;
   localparam logic [5:0] SECOND_RESET = 6'd57;

   localparam logic [5:0] LAST_MINUTE  = 6'd59;
   localparam logic [5:0] LAST_SECOND  = 6'd59;
   localparam logic [4:0] WRAP_HOUR_12 = 5'd12;
   localparam logic [4:0] WRAP_HOUR_24 = 5'd23;
   localparam logic [5:0] HALF_DAY     = 6'd12;
   localparam logic [5:0] FULL_DAY     = 6'd24;

   typedef struct packed {
      logic opcode;
      logic minute_button_level;
      logic mode_button_level;
   } req_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic       pm_flag;
      logic       twelve_hour_mode;
      logic       led_level;
      logic       buzzer_level;
      logic       second_advanced;
   } rsp_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic       pm;
   } time_type;

   // add one minute, carry into the hour and flip pm on the hour wrap
   function automatic time_type add_minute(time_type t, logic twelve);
      time_type   r;
      logic [4:0] wrap_hour;
      r = t;
      wrap_hour = twelve ? WRAP_HOUR_12 : WRAP_HOUR_24;
      if (t.minutes >= LAST_MINUTE) begin
         r.minutes = 6'd0;
         if (t.hours >= wrap_hour) begin
            r.hours = 5'd0;
            r.pm    = ~t.pm;
         end else begin
            r.hours = t.hours + 5'd1;
         end
      end else begin
         r.minutes = t.minutes + 6'd1;
      end
      return r;
   endfunction

   // convert the hour when the display mode flips away from 'twelve'
   function automatic logic [4:0] convert_hour(logic [4:0] hours, logic pm, logic twelve);
      logic [5:0] h;
      h = {1'b0, hours};
      if (!twelve) begin
         if (h > HALF_DAY) h = h - HALF_DAY;
      end else begin
         if (pm) h = h + HALF_DAY;
         if (h >= FULL_DAY) h = h - FULL_DAY;
      end
      return h[4:0];
   endfunction

endpackage

/* hdl/hms_clock_12_24_with_button_adjust.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hms_clock_12_24_with_button_adjust: hh:mm:ss clock with 12/24 mode
// Request channel (req_*): each request is a timebase tick or a button scan
// carrying the raw levels of the minute and mode buttons (0 = pressed).
// Result channel (rsp_*): one result per request with the time, pm flag,
// display mode, LED, buzzer and a flag for a second advance.
// Configuration (csr_*): index 0 ticks per second, index 1 debounce scans;
// always ready, write only while no request is in flight.
// An accepted request is held in the request register, worked out from it and
// moved into the result register, which drives rsp_valid, once that is free.
// Throughput: one request per cycle while req_stall is low; the step is a
// single pass of compares and increments between the request register and
// the result register. A held result does not block the request register:
// a new request is taken while the result waits, and req_stall rises only
// when both are full and rsp_stall is high.
// Reset: synchronous; time returns to 15:58:57 pm in 24-hour mode, counters,
// LED and buzzer clear, registers return to 8 and 10, both stages empty.
// ----------------------------------------------------------------------------
module hms_clock_12_24_with_button_adjust (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  hmsclk_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output hmsclk_pkg::rsp_type rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [7:0]          csr_data
);

   // request register
   logic                in_valid_ff, in_valid_in;
   hmsclk_pkg::req_type in_data_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   hmsclk_pkg::rsp_type rsp_data_ff;
   hmsclk_pkg::rsp_type step_result;

   // configuration
   logic [7:0] ticks_ff, ticks_in;
   logic [7:0] debounce_ff, debounce_in;

   logic fire;
   logic req_take;
   logic scan_fire;
   logic minute_press;
   logic mode_press;

   // move the held request into the result register when that slot frees
   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign scan_fire = fire && (in_data_ff.opcode == hmsclk_pkg::OP_SCAN);

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (fire) in_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (fire) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;

      ticks_in    = ticks_ff;
      debounce_in = debounce_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            hmsclk_pkg::CSR_TICKS_PER_SECOND: ticks_in    = csr_data;
            hmsclk_pkg::CSR_DEBOUNCE_SCANS:   debounce_in = csr_data;
            default: ;
         endcase
      end
   end

   // one rest counter per button
   hmsclk_debounce u_minute_debounce (
      .clock          (clock),
      .reset          (reset),
      .scan           (scan_fire),
      .level          (in_data_ff.minute_button_level),
      .debounce_scans (debounce_ff),
      .press          (minute_press)
   );

   hmsclk_debounce u_mode_debounce (
      .clock          (clock),
      .reset          (reset),
      .scan           (scan_fire),
      .level          (in_data_ff.mode_button_level),
      .debounce_scans (debounce_ff),
      .press          (mode_press)
   );

   hmsclk_core u_core (
      .clock            (clock),
      .reset            (reset),
      .fire             (fire),
      .item             (in_data_ff),
      .minute_press     (minute_press),
      .mode_press       (mode_press),
      .ticks_per_second (ticks_ff),
      .result           (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ticks_ff     <= hmsclk_pkg::TICKS_PER_SECOND_RESET;
         debounce_ff  <= hmsclk_pkg::DEBOUNCE_SCANS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ticks_ff     <= ticks_in;
         debounce_ff  <= debounce_in;
      end
   end

   // payload: hold while stalled, load on a take
   always_ff @(posedge clock) begin
      if (req_take) in_data_ff <= req_data;
      if (fire) rsp_data_ff <= step_result;
   end

endmodule

/* hdl/hmsclk_debounce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmsclk_debounce: button rest counter
// Counts scans with the button released, up to the configured limit, and
// flags a press on a pressed scan once the button has rested long enough.
// ----------------------------------------------------------------------------
module hmsclk_debounce (
   input  logic       clock,
   input  logic       reset,
   input  logic       scan,
   input  logic       level,
   input  logic [7:0] debounce_scans,
   output logic       press
);

   logic [7:0] rest_ff;
   logic [7:0] rest_in;

   always_comb begin
      rest_in = rest_ff;
      press   = 1'b0;
      if (scan) begin
         if (level) begin
            if (rest_ff < debounce_scans) rest_in = rest_ff + 8'd1;
         end else begin
            press   = (rest_ff >= debounce_scans);
            rest_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff <= 8'd0;
      end else begin
         rest_ff <= rest_in;
      end
   end

endmodule

/* hdl/hmsclk_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmsclk_core: time keeping state and step logic
// Holds the time, mode, LED, buzzer and prescale state and works out the
// state after one request in a single pass.
// ----------------------------------------------------------------------------
module hmsclk_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  hmsclk_pkg::req_type item,
   input  logic                minute_press,
   input  logic                mode_press,
   input  logic [7:0]          ticks_per_second,
   output hmsclk_pkg::rsp_type result
);

   hmsclk_pkg::time_type time_ff, time_in;
   logic       twelve_ff, twelve_in;
   logic       led_ff, led_in;
   logic       buzzer_ff, buzzer_in;
   logic [7:0] prescale_ff, prescale_in;
   logic       advanced;

   hmsclk_pkg::time_type t_sec;
   hmsclk_pkg::time_type t_min;

   always_comb begin
      time_in     = time_ff;
      twelve_in   = twelve_ff;
      led_in      = led_ff;
      buzzer_in   = buzzer_ff;
      prescale_in = prescale_ff;
      advanced    = 1'b0;

      // second advance with carry into the minute
      t_sec = time_ff;
      if (time_ff.seconds >= hmsclk_pkg::LAST_SECOND) begin
         t_sec.seconds = 6'd0;
         t_sec = hmsclk_pkg::add_minute(t_sec, twelve_ff);
      end else begin
         t_sec.seconds = time_ff.seconds + 6'd1;
      end

      // minute button acts before the mode button
      t_min = minute_press ? hmsclk_pkg::add_minute(time_ff, twelve_ff) : time_ff;

      if (item.opcode == hmsclk_pkg::OP_TIMEBASE) begin
         if (prescale_ff >= ticks_per_second) begin
            led_in      = ~led_ff;
            prescale_in = 8'd1;
            time_in     = t_sec;
            advanced    = 1'b1;
         end else begin
            prescale_in = prescale_ff + 8'd1;
         end
      end else begin
         time_in   = t_min;
         buzzer_in = buzzer_ff ^ minute_press ^ mode_press;
         if (mode_press) begin
            time_in.hours = hmsclk_pkg::convert_hour(t_min.hours, t_min.pm, twelve_ff);
            twelve_in     = ~twelve_ff;
         end
      end

      result.hours            = time_in.hours;
      result.minutes          = time_in.minutes;
      result.seconds          = time_in.seconds;
      result.pm_flag          = time_in.pm;
      result.twelve_hour_mode = twelve_in;
      result.led_level        = led_in;
      result.buzzer_level     = buzzer_in;
      result.second_advanced  = advanced;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff.hours   <= hmsclk_pkg::HOUR_RESET;
         time_ff.minutes <= hmsclk_pkg::MINUTE_RESET;
         time_ff.seconds <= hmsclk_pkg::SECOND_RESET;
         time_ff.pm      <= 1'b1;
         twelve_ff       <= 1'b0;
         led_ff          <= 1'b0;
         buzzer_ff       <= 1'b0;
         prescale_ff     <= 8'd0;
      end else if (fire) begin
         time_ff     <= time_in;
         twelve_ff   <= twelve_in;
         led_ff      <= led_in;
         buzzer_ff   <= buzzer_in;
         prescale_ff <= prescale_in;
      end
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the hh:mm:ss clock with 12/24 mode
// Streams timebase ticks and button scans through the request channel and
// checks every result against a cycle-free model of the clock kept inside
// the bench. Both channels idle at random, the result side holds off once for
// a long stretch, and the two registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb;

   localparam int CLOCK_PERIOD   = 12;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int IDLE_PERCENT   = 22;
   localparam int MAX_REPORTS    = 10;
   localparam int DRAIN_CYCLES   = 10;
   // request counts that frame the quiet stretch and start the long hold-off, and the hold-off length
   localparam int QUIET_FROM     = 700;
   localparam int QUIET_TO       = 950;
   localparam int HOLD_AT        = 400;
   localparam int HOLD_CYCLES    = 100;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   hmsclk_pkg::req_type req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   hmsclk_pkg::rsp_type rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic                csr_index;
   logic [7:0]          csr_data;

   hms_clock_12_24_with_button_adjust dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // requests waiting to be offered; the head is the one on req_data
   hmsclk_pkg::req_type pending_ticks[$];
   // clock readings predicted for requests already taken by the block
   hmsclk_pkg::rsp_type expected_times[$];

   int  queued;
   int  reqs_taken;
   int  results_seen;
   int  errors;
   int  cycle_count;
   bit  req_sent;
   bit  hold_done;
   int  hold_left;

   // ------------------------------------------------------------------------
   // Clock model: the bench's own copy of the registers and the time state
   // ------------------------------------------------------------------------
   logic [7:0] cfg_ticks;
   logic [7:0] cfg_debounce;
   logic [7:0] tick_count;
   logic [4:0] clk_hours;
   logic [5:0] clk_minutes;
   logic [5:0] clk_seconds;
   logic       clk_pm;
   logic       clk_twelve;
   logic [7:0] minute_rest;
   logic [7:0] mode_rest;
   logic       led_q;
   logic       buzz_q;

   task automatic bump_minute();
      logic [4:0] wrap_hour;
      wrap_hour = clk_twelve ? hmsclk_pkg::WRAP_HOUR_12 : hmsclk_pkg::WRAP_HOUR_24;
      if (clk_minutes >= hmsclk_pkg::LAST_MINUTE) begin
         clk_minutes = 6'd0;
         // an hour past the wrap point wraps as if it sat on it
         if (clk_hours >= wrap_hour) begin
            clk_hours = 5'd0;
            clk_pm    = ~clk_pm;
         end else begin
            clk_hours = clk_hours + 5'd1;
         end
      end else begin
         clk_minutes = clk_minutes + 6'd1;
      end
   endtask

   task automatic flip_mode();
      logic [5:0] h;
      if (!clk_twelve) begin
         clk_twelve = 1'b1;
         if (clk_hours > 5'd12) clk_hours = clk_hours - 5'd12;
      end else begin
         clk_twelve = 1'b0;
         h = {1'b0, clk_hours};
         if (clk_pm) h = h + hmsclk_pkg::HALF_DAY;
         // 12 pm in 12-hour form lands on 24, which reads as midnight
         if (h >= hmsclk_pkg::FULL_DAY) h = h - hmsclk_pkg::FULL_DAY;
         clk_hours = h[4:0];
      end
   endtask

   // released levels build up rest; a press counts once rest reaches the limit
   task automatic debounce_button(inout logic [7:0] rest, input logic level,
                                  output logic hit);
      hit = 1'b0;
      if (level) begin
         if (rest < cfg_debounce) rest = rest + 8'd1;
      end else begin
         hit  = (rest >= cfg_debounce);
         rest = 8'd0;
      end
   endtask

   task automatic advance_clock(input hmsclk_pkg::req_type r,
                                output hmsclk_pkg::rsp_type o);
      logic hit;
      o.second_advanced = 1'b0;
      if (r.opcode == hmsclk_pkg::OP_TIMEBASE) begin
         if (tick_count >= cfg_ticks) begin
            led_q      = ~led_q;
            tick_count = 8'd1;
            if (clk_seconds >= hmsclk_pkg::LAST_SECOND) begin
               clk_seconds = 6'd0;
               bump_minute();
            end else begin
               clk_seconds = clk_seconds + 6'd1;
            end
            o.second_advanced = 1'b1;
         end else begin
            tick_count = tick_count + 8'd1;
         end
      end else begin
         // minute button first, then the mode button
         debounce_button(minute_rest, r.minute_button_level, hit);
         if (hit) begin
            bump_minute();
            buzz_q = ~buzz_q;
         end
         debounce_button(mode_rest, r.mode_button_level, hit);
         if (hit) begin
            buzz_q = ~buzz_q;
            flip_mode();
         end
      end
      o.hours            = clk_hours;
      o.minutes          = clk_minutes;
      o.seconds          = clk_seconds;
      o.pm_flag          = clk_pm;
      o.twelve_hour_mode = clk_twelve;
      o.led_level        = led_q;
      o.buzzer_level     = buzz_q;
   endtask

   function automatic string show_time(hmsclk_pkg::rsp_type t);
      return $sformatf("%0d:%0d:%0d pm=%b 12h=%b led=%b buz=%b adv=%b",
                       t.hours, t.minutes, t.seconds, t.pm_flag,
                       t.twelve_hour_mode, t.led_level, t.buzzer_level,
                       t.second_advanced);
   endfunction

   // ------------------------------------------------------------------------
   // Clock generator and run limit
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_times.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // quiet stretch: neither side idles while these requests go through
   function automatic bit in_quiet_stretch();
      return reqs_taken >= QUIET_FROM && reqs_taken < QUIET_TO;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: advance on the falling edge, hold the payload while
   // the block stalls it
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!req_valid || req_sent) begin
         req_sent = 1'b0;
         if (pending_ticks.size() > 0 &&
             (in_quiet_stretch() || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            req_valid <= 1'b1;
            req_data  <= pending_ticks[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result stall driver: random idling, plus one long hold-off so the
   // block fills up and pushes back on the request side
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && reqs_taken >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (in_quiet_stretch()) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: sample both handshakes on the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      hmsclk_pkg::rsp_type predicted;
      hmsclk_pkg::rsp_type want;
      if (!reset) begin
         // check the result first: it always belongs to an older request
         if (rsp_valid && !rsp_stall) begin
            results_seen = results_seen + 1;
            if (expected_times.size() == 0) begin
               errors = errors + 1;
               if (errors <= MAX_REPORTS)
                  $display("unexpected result %0d: %s", results_seen,
                           show_time(rsp_data));
            end else begin
               want = expected_times.pop_front();
               if (rsp_data !== want) begin
                  errors = errors + 1;
                  if (errors <= MAX_REPORTS)
                     $display("result %0d mismatch: expected %s, got %s",
                              results_seen, show_time(want), show_time(rsp_data));
               end
            end
         end
         if (req_valid && !req_stall) begin
            advance_clock(pending_ticks.pop_front(), predicted);
            expected_times.push_back(predicted);
            reqs_taken = reqs_taken + 1;
            req_sent   = 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_item(input logic op, input logic minute_lvl, input logic mode_lvl);
      hmsclk_pkg::req_type r;
      r.opcode              = op;
      r.minute_button_level = minute_lvl;
      r.mode_button_level   = mode_lvl;
      pending_ticks.push_back(r);
      queued = queued + 1;
   endtask

   // timebase ticks carry junk on the button pins; the block must ignore it
   task automatic push_tick();
      push_item(hmsclk_pkg::OP_TIMEBASE, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
   endtask

   // a run of released scans followed by a press; now and then one scan short
   task automatic queue_press_train(input int deb);
      int rest;
      int pick;
      rest = deb + int'($urandom_range(0, 1));
      if (deb > 0 && $urandom_range(0, 4) == 0) rest = deb - 1;
      pick = int'($urandom_range(0, 2));
      repeat (rest) begin
         if ($urandom_range(0, 3) == 0) push_tick();
         push_item(hmsclk_pkg::OP_SCAN, 1'b1, 1'b1);
      end
      // 0: minute only, 1: mode only, 2: both at once
      push_item(hmsclk_pkg::OP_SCAN, pick == 1, pick == 0);
   endtask

   // wait until every taken request has come back, then let the pipe empty
   task automatic settle();
      while (pending_ticks.size() > 0 || expected_times.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == hmsclk_pkg::CSR_TICKS_PER_SECOND) cfg_ticks = value;
      else cfg_debounce = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [7:0] ticks, input logic [7:0] deb, input int n);
      write_csr(hmsclk_pkg::CSR_TICKS_PER_SECOND, ticks);
      write_csr(hmsclk_pkg::CSR_DEBOUNCE_SCANS, deb);
      queued = 0;
      while (queued < n) begin
         if ($urandom_range(0, 99) < 70)
            queue_press_train(int'(deb));
         else
            push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
      end
      settle();
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_stall    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = hmsclk_pkg::CSR_TICKS_PER_SECOND;
      csr_data     = 8'd0;
      queued       = 0;
      reqs_taken   = 0;
      results_seen = 0;
      errors       = 0;
      cycle_count  = 0;
      req_sent     = 1'b0;
      hold_done    = 1'b0;
      hold_left    = 0;

      cfg_ticks    = hmsclk_pkg::TICKS_PER_SECOND_RESET;
      cfg_debounce = hmsclk_pkg::DEBOUNCE_SCANS_RESET;
      tick_count   = 8'd0;
      clk_hours    = hmsclk_pkg::HOUR_RESET;
      clk_minutes  = hmsclk_pkg::MINUTE_RESET;
      clk_seconds  = hmsclk_pkg::SECOND_RESET;
      clk_pm       = 1'b1;
      clk_twelve   = 1'b0;
      minute_rest  = 8'd0;
      mode_rest    = 8'd0;
      led_q        = 1'b0;
      buzz_q       = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: a couple of ticks, let both buttons rest past the
      // debounce limit, then a minute press right on the limit
      push_tick();
      push_tick();
      repeat (11) push_item(hmsclk_pkg::OP_SCAN, 1'b1, 1'b1);
      push_item(hmsclk_pkg::OP_SCAN, 1'b0, 1'b1);
      settle();

      // drop the debounce limit below the mode rest count; the press must
      // still count. Zero ticks per second: every tick advances the time.
      write_csr(hmsclk_pkg::CSR_TICKS_PER_SECOND, 8'd0);
      write_csr(hmsclk_pkg::CSR_DEBOUNCE_SCANS, 8'd3);
      push_item(hmsclk_pkg::OP_SCAN, 1'b1, 1'b0);
      repeat (4) push_tick();
      push_item(hmsclk_pkg::OP_SCAN, 1'b0, 1'b0);
      settle();

      // zero debounce: every pressed scan counts, both at once toggle twice
      write_csr(hmsclk_pkg::CSR_DEBOUNCE_SCANS, 8'd0);
      push_item(hmsclk_pkg::OP_SCAN, 1'b0, 1'b0);
      push_item(hmsclk_pkg::OP_SCAN, 1'b1, 1'b0);
      push_item(hmsclk_pkg::OP_SCAN, 1'b1, 1'b0);
      push_item(hmsclk_pkg::OP_SCAN, 1'b0, 1'b1);
      push_item(hmsclk_pkg::OP_SCAN, 1'b1, 1'b1);
      settle();

      // random phases across the register extremes
      run_phase(8'd1,   8'd0,   300);
      run_phase(8'd255, 8'd255, 260);
      run_phase(8'd0,   8'd1,   250);
      run_phase(8'd2,   8'd4,   250);
      run_phase(8'($urandom_range(1, 20)), 8'($urandom_range(0, 12)), 250);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_times.size() != 0) errors = errors + 1;
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
